// ----- sv/ucfp_pkg.sv -----
package ucfp_pkg;

    // Byte width of the packed result bus and the fixed output field widths.
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned CHARS_W  = 56;
    localparam int unsigned RES_W    = CODE_W + LEN_W + CHARS_W;
    localparam int unsigned TDATA_W  = ((RES_W + 7) / 8) * 8;
    localparam int unsigned PAD_W    = TDATA_W - RES_W;

    typedef struct packed {
        logic               is_set;
        logic [CODE_W-1:0]  param_code;
        logic [LEN_W-1:0]   value_length;
        logic [CHARS_W-1:0] value_chars;
    } t_result;

endpackage

// ----- sv/ucfp_parser.sv -----
module ucfp_parser #(
    parameter int unsigned MAX_DIGITS = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_room,
    output logic              o_res_valid,
    output ucfp_pkg::t_result o_res
);

    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READY = 3'd1;
    localparam logic [2:0] ST_GET   = 3'd2;
    localparam logic [2:0] ST_SET   = 3'd3;
    localparam logic [2:0] ST_PARAM = 3'd4;
    localparam logic [2:0] ST_VALUE = 3'd5;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_K     = 8'h6B;

    function automatic logic get_letter_ok(input logic [7:0] b);
        return (b == CH_T) || (b == CH_C) || (b == CH_A) || (b == CH_P) ||
               (b == CH_I) || (b == CH_D) || (b == CH_S) || (b == CH_G) ||
               (b == CH_R) || (b == CH_M);
    endfunction

    function automatic logic set_letter_ok(input logic [7:0] b);
        return (b == CH_T) || (b == CH_I) || (b == CH_C) || (b == CH_A) ||
               (b == CH_P) || (b == CH_D) || (b == CH_S) || (b == CH_B) ||
               (b == CH_N) || (b == CH_M) || (b == CH_K);
    endfunction

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic [2:0]    r_state, n_state;
    logic [7:0]    r_letter, n_letter;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_store [MAX_DIGITS];
    logic [7:0]    n_store [MAX_DIGITS];

    logic          w_step;
    logic          w_emit;
    logic          w_kind;
    logic          w_value_char;
    logic [63:0]   w_store_flat;
    logic [7:0]    w_count_ext;

    assign w_step     = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || w_step;

    assign w_value_char = ((r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE)) ||
                          (r_in_byte == CH_COMMA);

    always_comb begin
        n_state = r_state;
        n_letter = r_letter;
        n_count = r_count;
        n_store = r_store;
        w_emit = 1'b0;
        w_kind = 1'b0;
        if (r_in_byte == CH_HASH) begin
            n_state = ST_READY;
        end else begin
            case (r_state)
                ST_READY: begin
                    if (r_in_byte == CH_G) begin
                        n_state = ST_GET;
                    end else if (r_in_byte == CH_S) begin
                        n_state = ST_SET;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_GET: begin
                    if (get_letter_ok(r_in_byte)) begin
                        n_letter = r_in_byte;
                        n_state = ST_PARAM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_SET: begin
                    if (set_letter_ok(r_in_byte)) begin
                        n_letter = r_in_byte;
                        n_count = '0;
                        for (int i = 0; i < MAX_DIGITS; i++) begin
                            n_store[i] = 8'h00;
                        end
                        n_state = ST_VALUE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_PARAM: begin
                    n_state = ST_IDLE;
                    w_emit = (r_in_byte == CH_SEMI);
                end
                ST_VALUE: begin
                    if (w_value_char) begin
                        // Characters past the storage limit are dropped, frame stays open.
                        if (r_count < CW'(MAX_DIGITS)) begin
                            n_store[r_count[IW-1:0]] = r_in_byte;
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_state = ST_IDLE;
                        w_emit = (r_in_byte == CH_SEMI);
                        w_kind = 1'b1;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        w_store_flat = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_store_flat[8*i +: 8] = r_store[i];
        end
    end

    assign w_count_ext = 8'(r_count);

    assign o_res_valid        = w_step && w_emit;
    assign o_res.is_set       = w_kind;
    assign o_res.param_code   = r_letter;
    assign o_res.value_length = w_kind ? w_count_ext[ucfp_pkg::LEN_W-1:0] : '0;
    assign o_res.value_chars  = w_kind ? w_store_flat[ucfp_pkg::CHARS_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_letter <= 8'h00;
            r_count <= '0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= 8'h00;
            end
        end else if (w_step) begin
            r_state <= n_state;
            r_letter <= n_letter;
            r_count <= n_count;
            r_store <= n_store;
        end
    end

endmodule

// ----- sv/ucfp_out_fifo.sv -----
module ucfp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ucfp_pkg::t_result i_data,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output ucfp_pkg::t_result o_data
);

    ucfp_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/uart_command_frame_parser.sv -----
// Command frame parser for a byte-serial control link.
// The slave stream takes one received character per item in tdata[7:0].
// The parser follows frames of the form '#', g or s, a parameter letter,
// for set frames digits or commas (at most MAX_DIGITS kept), then ';'. A '#'
// restarts the frame from any position; any other unexpected byte drops
// the frame without a result.
// Each frame closed by ';' gives one item on the master stream: tuser is
// the kind (1 for set), tdata carries the letter, the kept character
// count and the kept characters, first character in the low byte.
// A closing byte passes the input register, then the result queue, before it
// appears on the master stream. Throughput is one byte per cycle while the
// result queue has room; the state update sits between the input register
// and the two-entry result queue.
// When the receiver stalls, the queue absorbs results; input stops being
// accepted only while the queue is full and a byte waits in the input
// register. Reset returns the parser to idle and empties the queue.
module uart_command_frame_parser #(
    parameter int unsigned MAX_DIGITS = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] rx_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] param_code, [10:8] value_length, [66:11] value_chars, rest zero
    output logic [ucfp_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic                           o_m_axis_tuser   // [0] is_set
);

    logic              w_room;
    logic              w_res_valid;
    ucfp_pkg::t_result w_res;
    ucfp_pkg::t_result w_out;

    ucfp_parser #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_byte   (i_s_axis_tdata),
        .i_room      (w_room),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ucfp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out)
    );

    assign o_m_axis_tuser = w_out.is_set;
    assign o_m_axis_tdata = {{ucfp_pkg::PAD_W{1'b0}}, w_out.value_chars,
                             w_out.value_length, w_out.param_code};

endmodule
